@@ design/smid_pkg.sv @@
// Shared constants, register indexes and control types for the idle detector.
`timescale 1ns / 1ps
package smid_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_WIDTH    = 16;
    localparam int STRESS_WIDTH = 8;
    localparam int SINCE_WIDTH  = 32;

    localparam logic [STRESS_WIDTH-1:0] STRESS_BAND  = 8'd16;
    localparam logic [CFG_WIDTH-1:0]    THRESH_FLOOR = 16'd1;
    localparam logic [7:0]              ROUND_HALF   = 8'd127;
    localparam int                      STRESS_MAX   = 255;

    // floor(x / 255) for x below 2**24: (x * RECIP_MUL) >> RECIP_SHIFT, then at most one down step
    localparam logic [15:0] RECIP_MUL   = 16'd32897;
    localparam int          RECIP_SHIFT = 23;

    localparam logic [CFG_WIDTH-1:0] BASE_THRESHOLD_RST = 16'd30;
    localparam logic [CFG_WIDTH-1:0] LOG_CADENCE_RST    = 16'd10;
    localparam logic [CFG_WIDTH-1:0] WORK_CADENCE_RST   = 16'd10;

    typedef enum logic [1:0] {
        CFG_BASE_THRESHOLD = 2'd0,
        CFG_LOG_CADENCE    = 2'd1,
        CFG_WORK_CADENCE   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic thr;
        logic cmp;
        logic write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_kind;
        logic hit;
        logic mod_done;
        logic out_busy;
    } dp_status_t;

endpackage

@@ design/stress_modulated_idle_detector.sv @@
// Top level of the stress-modulated idle detector.
// Each request is a heartbeat tick (kind 0, with a stress sample) or a stimulus
// (kind 1) and yields exactly one result. A stimulus goes from accept straight
// to the result write. A tick that stays below the threshold passes through
// accept and span product, reciprocal multiply for the divide by 255, threshold
// update, compare, one pass through the remainder wait, and result. A tick that
// counts an idle run waits in the remainder state for the bit-serial remainders
// against the work and log cadences, which run side by side. The result sits in
// an output register, so input is taken again as soon as the result is loaded;
// a stalled output holds the next request in its final cycle. Configuration
// writes are always ready and take effect at once.
`timescale 1ns / 1ps
module stress_modulated_idle_detector
    import smid_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    kind,
    input  logic [STRESS_WIDTH-1:0] stress_level,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    is_idle,
    output logic                    entered_idle,
    output logic                    woke_up,
    output logic                    idle_work_due,
    output logic                    cadence_work_due,
    output logic                    log_due,
    output logic [CFG_WIDTH-1:0]    effective_threshold,
    output logic [SINCE_WIDTH-1:0]  ticks_since_stimulus,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    smid_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    smid_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .cfg_valid            (cfg_valid && cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .kind                 (kind),
        .stress_level         (stress_level),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .is_idle              (is_idle),
        .entered_idle         (entered_idle),
        .woke_up              (woke_up),
        .idle_work_due        (idle_work_due),
        .cadence_work_due     (cadence_work_due),
        .log_due              (log_due),
        .effective_threshold  (effective_threshold),
        .ticks_since_stimulus (ticks_since_stimulus)
    );

endmodule

@@ design/smid_mod.sv @@
// Bit-serial remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module smid_mod
    import smid_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] dividend,
    input  logic [CFG_WIDTH-1:0]   divisor,
    output logic [CFG_WIDTH-1:0]   remainder,
    output logic                   done
);

    localparam int CNT_W = $clog2(COUNT_WIDTH + 1);

    logic [COUNT_WIDTH-1:0] quo_reg, quo_next;
    logic [CFG_WIDTH-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CFG_WIDTH-1:0]   div_eff;
    logic [CFG_WIDTH:0]     rem_shift;

    assign div_eff   = (divisor == '0) ? CFG_WIDTH'(1) : divisor;
    assign rem_shift = {rem_reg, quo_reg[COUNT_WIDTH-1]};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(COUNT_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[COUNT_WIDTH-2:0], 1'b0};
            if (rem_shift >= {1'b0, div_eff})
            begin
                rem_next = CFG_WIDTH'(rem_shift - {1'b0, div_eff});
            end
            else
            begin
                rem_next = rem_shift[CFG_WIDTH-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign done      = (cnt_reg == '0);

endmodule

@@ design/smid_datapath.sv @@
// Datapath: configuration, detector state, threshold arithmetic and result register.
`timescale 1ns / 1ps
module smid_datapath
    import smid_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              status,
    input  logic                    cfg_valid,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_data,
    input  logic                    kind,
    input  logic [STRESS_WIDTH-1:0] stress_level,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    is_idle,
    output logic                    entered_idle,
    output logic                    woke_up,
    output logic                    idle_work_due,
    output logic                    cadence_work_due,
    output logic                    log_due,
    output logic [CFG_WIDTH-1:0]    effective_threshold,
    output logic [SINCE_WIDTH-1:0]  ticks_since_stimulus
);

    localparam int SW = (COUNT_WIDTH < SINCE_WIDTH) ? COUNT_WIDTH : SINCE_WIDTH;
    localparam int PW = CFG_WIDTH + STRESS_WIDTH;
    localparam int QW = PW - 7;

    logic [CFG_WIDTH-1:0]    base_reg, logc_reg, workc_reg;
    logic [COUNT_WIDTH-1:0]  tick_reg, last_reg, run_reg, since_reg;
    logic                    idle_reg, seeded_reg, recalc_reg;
    logic                    hit_reg, entered_reg, woke_reg;
    logic [STRESS_WIDTH-1:0] held_stress_reg, stress_reg;
    logic [CFG_WIDTH-1:0]    held_thr_reg, span_reg;
    logic [PW-1:0]           prod_reg, x_reg;
    logic [QW-1:0]           q0_reg;

    logic                    out_valid_reg;
    logic                    is_idle_reg, entered_out_reg, woke_out_reg;
    logic                    work_out_reg, cad_out_reg, log_out_reg;
    logic [CFG_WIDTH-1:0]    thr_out_reg;
    logic [SINCE_WIDTH-1:0]  since_out_reg;

    logic [CFG_WIDTH-1:0]    base_eff, span_w;
    logic [COUNT_WIDTH-1:0]  tick_next, run_next;
    logic [STRESS_WIDTH-1:0] stress_diff;
    logic [PW-1:0]           x_w;
    logic [PW+15:0]          recip_prod;
    logic [QW+7:0]           q0_times;
    logic [QW-1:0]           cut_w;
    logic [CFG_WIDTH-1:0]    thr_new;
    logic                    hit_w;
    logic [CFG_WIDTH-1:0]    rem_work, rem_log;
    logic                    done_work, done_log;
    logic                    out_busy;

    assign base_eff    = (base_reg == '0) ? THRESH_FLOOR : base_reg;
    assign span_w      = base_eff - THRESH_FLOOR;
    assign tick_next   = tick_reg + COUNT_WIDTH'(1);
    assign run_next    = run_reg + COUNT_WIDTH'(1);
    assign stress_diff = (stress_level >= held_stress_reg) ? stress_level - held_stress_reg
                                                           : held_stress_reg - stress_level;

    assign x_w        = prod_reg + PW'(ROUND_HALF);
    assign recip_prod = (PW+16)'(x_w) * (PW+16)'(RECIP_MUL);
    assign q0_times   = {q0_reg, 8'd0} - (QW+8)'(q0_reg);
    assign cut_w      = (q0_times > (QW+8)'(x_reg)) ? q0_reg - QW'(1) : q0_reg;
    assign thr_new    = (cut_w >= QW'(span_reg)) ? THRESH_FLOOR
                                                 : span_reg + THRESH_FLOOR - CFG_WIDTH'(cut_w);
    assign hit_w      = (since_reg >= COUNT_WIDTH'(held_thr_reg));

    assign out_busy = out_valid_reg && out_stall;

    assign status.in_kind  = kind;
    assign status.hit      = hit_reg;
    assign status.mod_done = done_work && done_log;
    assign status.out_busy = out_busy;

    smid_mod #(.COUNT_WIDTH(COUNT_WIDTH)) u_mod_work (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.cmp && hit_w),
        .dividend  (run_next),
        .divisor   (workc_reg),
        .remainder (rem_work),
        .done      (done_work)
    );

    smid_mod #(.COUNT_WIDTH(COUNT_WIDTH)) u_mod_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.cmp && hit_w),
        .dividend  (run_next),
        .divisor   (logc_reg),
        .remainder (rem_log),
        .done      (done_log)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= BASE_THRESHOLD_RST;
            logc_reg        <= LOG_CADENCE_RST;
            workc_reg       <= WORK_CADENCE_RST;
            tick_reg        <= '0;
            last_reg        <= '0;
            run_reg         <= '0;
            idle_reg        <= 1'b0;
            seeded_reg      <= 1'b0;
            held_stress_reg <= '0;
            held_thr_reg    <= BASE_THRESHOLD_RST;
            recalc_reg      <= 1'b0;
            hit_reg         <= 1'b0;
            entered_reg     <= 1'b0;
            woke_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BASE_THRESHOLD: base_reg  <= cfg_data;
                    CFG_LOG_CADENCE:    logc_reg  <= cfg_data;
                    CFG_WORK_CADENCE:   workc_reg <= cfg_data;
                    default:            ;
                endcase
            end

            if (cmd.accept)
            begin
                hit_reg     <= 1'b0;
                entered_reg <= 1'b0;
                woke_reg    <= 1'b0;
                recalc_reg  <= !seeded_reg || (stress_diff >= STRESS_BAND);
                if (kind)
                begin
                    last_reg <= tick_reg;
                    if (idle_reg)
                    begin
                        idle_reg <= 1'b0;
                        woke_reg <= 1'b1;
                    end
                end
                else
                begin
                    tick_reg <= tick_next;
                end
            end

            if (cmd.thr && recalc_reg)
            begin
                seeded_reg      <= 1'b1;
                held_stress_reg <= stress_reg;
                held_thr_reg    <= thr_new;
            end

            if (cmd.cmp && hit_w)
            begin
                hit_reg     <= 1'b1;
                idle_reg    <= 1'b1;
                entered_reg <= !idle_reg;
                run_reg     <= run_next;
            end

            if (cmd.write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stress_reg <= stress_level;
            span_reg   <= span_w;
            prod_reg   <= PW'(span_w) * PW'(stress_level);
            since_reg  <= kind ? '0 : tick_next - last_reg;
        end
        if (cmd.mul)
        begin
            x_reg  <= x_w;
            q0_reg <= recip_prod[RECIP_SHIFT +: QW];
        end
        if (cmd.write)
        begin
            is_idle_reg     <= idle_reg;
            entered_out_reg <= entered_reg;
            woke_out_reg    <= woke_reg;
            work_out_reg    <= hit_reg;
            cad_out_reg     <= hit_reg && (rem_work == CFG_WIDTH'(1));
            log_out_reg     <= hit_reg && (rem_log == CFG_WIDTH'(1));
            thr_out_reg     <= held_thr_reg;
            since_out_reg   <= SINCE_WIDTH'(since_reg[SW-1:0]);
        end
    end

    assign out_valid            = out_valid_reg;
    assign is_idle              = is_idle_reg;
    assign entered_idle         = entered_out_reg;
    assign woke_up              = woke_out_reg;
    assign idle_work_due        = work_out_reg;
    assign cadence_work_due     = cad_out_reg;
    assign log_due              = log_out_reg;
    assign effective_threshold  = thr_out_reg;
    assign ticks_since_stimulus = since_out_reg;

endmodule

@@ design/smid_controller.sv @@
// Controller state machine: sequences one request through the datapath.
`timescale 1ns / 1ps
module smid_controller
    import smid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_THR   = 6'b000100,
        S_CMP   = 6'b001000,
        S_MOD   = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.in_kind ? S_WRITE : S_MUL;
                end
            end
            S_MUL:   state_next = S_THR;
            S_THR:   state_next = S_CMP;
            S_CMP:   state_next = S_MOD;
            S_MOD:
            begin
                if (!status.hit || status.mod_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.accept = (state_reg == S_IDLE) && in_valid;
    assign cmd.mul    = (state_reg == S_MUL);
    assign cmd.thr    = (state_reg == S_THR);
    assign cmd.cmp    = (state_reg == S_CMP);
    assign cmd.write  = (state_reg == S_WRITE) && !status.out_busy;

endmodule

@@ design/smid_checker.sv @@
// Port-level checker for the idle detector, bound to the top level.
`timescale 1ns / 1ps
module smid_checker
    import smid_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic                    is_idle,
    input logic                    entered_idle,
    input logic                    woke_up,
    input logic                    idle_work_due,
    input logic                    cadence_work_due,
    input logic                    log_due,
    input logic [SINCE_WIDTH-1:0]  ticks_since_stimulus
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_enter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entered_idle |-> is_idle && idle_work_due && !woke_up)
        else $error("entered_idle without idle run");

    a_wake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && woke_up |-> !is_idle && !idle_work_due && ticks_since_stimulus == '0)
        else $error("woke_up with inconsistent result");

    a_cadence: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cadence_work_due || log_due) |-> idle_work_due && is_idle)
        else $error("cadence flag without idle run");

    a_run_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && idle_work_due |-> is_idle)
        else $error("idle run counted while active");

endmodule

bind stress_modulated_idle_detector smid_checker u_smid_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .is_idle              (is_idle),
    .entered_idle         (entered_idle),
    .woke_up              (woke_up),
    .idle_work_due        (idle_work_due),
    .cadence_work_due     (cadence_work_due),
    .log_due              (log_due),
    .ticks_since_stimulus (ticks_since_stimulus)
);

@@ tb/tb_stress_modulated_idle_detector.sv @@
// Testbench for the stress-modulated idle detector: random ticks and stimuli vs a predictor.
`timescale 1ns / 1ps
module tb_stress_modulated_idle_detector;
    import smid_pkg::*;

    typedef struct packed {
        logic                   is_idle;
        logic                   entered_idle;
        logic                   woke_up;
        logic                   idle_work_due;
        logic                   cadence_work_due;
        logic                   log_due;
        logic [CFG_WIDTH-1:0]   effective_threshold;
        logic [SINCE_WIDTH-1:0] ticks_since_stimulus;
    } detector_result_t;

    class idle_detector_tracker;
        logic [CFG_WIDTH-1:0]   base_threshold = BASE_THRESHOLD_RST;
        logic [CFG_WIDTH-1:0]   log_cadence    = LOG_CADENCE_RST;
        logic [CFG_WIDTH-1:0]   work_cadence   = WORK_CADENCE_RST;
        logic [31:0]            tick_count     = '0;
        logic [31:0]            last_stimulus  = '0;
        logic                   idle           = 1'b0;
        logic [31:0]            run_total      = '0;
        logic [7:0]             held_stress    = '0;
        logic                   seeded         = 1'b0;
        logic [CFG_WIDTH-1:0]   held_threshold = BASE_THRESHOLD_RST;
        detector_result_t       pending_results[$];
        int requests = 0;
        int results_seen = 0;
        int mismatches = 0;
        int entries = 0;
        int wakeups = 0;
        int work_flags = 0;
        int log_flags = 0;
        int threshold_moves = 0;

        function logic [CFG_WIDTH-1:0] scaled_threshold(logic [CFG_WIDTH-1:0] base,
                                                        logic [7:0] stress);
            logic [CFG_WIDTH-1:0] b;
            logic [31:0] span;
            logic [31:0] cut;
            b = (base == 0) ? THRESH_FLOOR : base;
            if (b <= THRESH_FLOOR)
                return b;
            span = 32'(b) - 32'(THRESH_FLOOR);
            cut = (span * 32'(stress) + 32'(ROUND_HALF)) / 32'(STRESS_MAX);
            if (cut >= span)
                return THRESH_FLOOR;
            return b - cut[CFG_WIDTH-1:0];
        endfunction

        function void write_register(cfg_index_t idx, logic [CFG_WIDTH-1:0] value);
            case (idx)
                CFG_BASE_THRESHOLD: base_threshold = value;
                CFG_LOG_CADENCE:    log_cadence = value;
                CFG_WORK_CADENCE:   work_cadence = value;
                default: ;
            endcase
        endfunction

        function void apply_request(logic is_stimulus, logic [7:0] stress);
            detector_result_t r;
            logic [7:0] stress_delta;
            logic [31:0] work_div;
            logic [31:0] log_div;
            r = '0;
            requests++;
            if (is_stimulus)
            begin
                last_stimulus = tick_count;
                if (idle)
                begin
                    idle = 1'b0;
                    r.woke_up = 1'b1;
                    wakeups++;
                end
            end
            else
            begin
                tick_count = tick_count + 32'd1;
                r.ticks_since_stimulus = tick_count - last_stimulus;
                stress_delta = (stress >= held_stress) ? stress - held_stress
                                                       : held_stress - stress;
                if (!seeded || stress_delta >= STRESS_BAND)
                begin
                    seeded = 1'b1;
                    held_stress = stress;
                    held_threshold = scaled_threshold(base_threshold, stress);
                    threshold_moves++;
                end
                if (r.ticks_since_stimulus >= 32'(held_threshold))
                begin
                    if (!idle)
                    begin
                        idle = 1'b1;
                        r.entered_idle = 1'b1;
                        entries++;
                    end
                    run_total = run_total + 32'd1;
                    work_div = (work_cadence == 0) ? 32'd1 : 32'(work_cadence);
                    log_div = (log_cadence == 0) ? 32'd1 : 32'(log_cadence);
                    r.idle_work_due = 1'b1;
                    r.cadence_work_due = (run_total % work_div) == 32'd1;
                    r.log_due = (run_total % log_div) == 32'd1;
                    if (r.cadence_work_due)
                        work_flags++;
                    if (r.log_due)
                        log_flags++;
                end
            end
            r.is_idle = idle;
            r.effective_threshold = held_threshold;
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in result %0d, %s: expected %0h, got %0h",
                             results_seen, name, want, got);
            end
        endfunction

        function void compare_result(detector_result_t got);
            detector_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no request pending", results_seen);
                return;
            end
            want = pending_results.pop_front();
            check_field("is_idle", 32'(want.is_idle), 32'(got.is_idle));
            check_field("entered_idle", 32'(want.entered_idle), 32'(got.entered_idle));
            check_field("woke_up", 32'(want.woke_up), 32'(got.woke_up));
            check_field("idle_work_due", 32'(want.idle_work_due), 32'(got.idle_work_due));
            check_field("cadence_work_due", 32'(want.cadence_work_due),
                        32'(got.cadence_work_due));
            check_field("log_due", 32'(want.log_due), 32'(got.log_due));
            check_field("effective_threshold", 32'(want.effective_threshold),
                        32'(got.effective_threshold));
            check_field("ticks_since_stimulus", want.ticks_since_stimulus,
                        got.ticks_since_stimulus);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    kind = 1'b0;
    logic [STRESS_WIDTH-1:0] stress_level = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    is_idle;
    logic                    entered_idle;
    logic                    woke_up;
    logic                    idle_work_due;
    logic                    cadence_work_due;
    logic                    log_due;
    logic [CFG_WIDTH-1:0]    effective_threshold;
    logic [SINCE_WIDTH-1:0]  ticks_since_stimulus;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = CFG_BASE_THRESHOLD;
    logic [CFG_WIDTH-1:0]    cfg_data = '0;

    idle_detector_tracker tracker = new();
    logic [7:0] last_stress = '0;
    int settings_used = 1;
    int stall_cycle = 0;
    int stall_hold = 0;

    logic [CFG_WIDTH-1:0] fixed_base [6] = '{16'd1, 16'd0, 16'hFFFF, 16'd4, 16'd12, 16'd2};
    logic [CFG_WIDTH-1:0] fixed_log  [6] = '{16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd5, 16'd3};
    logic [CFG_WIDTH-1:0] fixed_work [6] = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd7, 16'd2};

    stress_modulated_idle_detector u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .kind                 (kind),
        .stress_level         (stress_level),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .is_idle              (is_idle),
        .entered_idle         (entered_idle),
        .woke_up              (woke_up),
        .idle_work_due        (idle_work_due),
        .cadence_work_due     (cadence_work_due),
        .log_due              (log_due),
        .effective_threshold  (effective_threshold),
        .ticks_since_stimulus (ticks_since_stimulus),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("** stress_modulated_idle_detector: FAILED **");
        $finish;
    end

    // receiver stall pattern: rotate through none, sparse, long runs and heavy
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_cycle <= stall_cycle + 1;
            case (stall_cycle[9:8])
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= ($urandom_range(0, 3) == 0);
                2'd2:
                begin
                    if (stall_hold != 0)
                    begin
                        stall_hold <= stall_hold - 1;
                    end
                    else
                    begin
                        out_stall <= ~out_stall;
                        stall_hold <= int'($urandom_range(0, 11));
                    end
                end
                default: out_stall <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk)
    begin : result_monitor
        detector_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.is_idle = is_idle;
            got.entered_idle = entered_idle;
            got.woke_up = woke_up;
            got.idle_work_due = idle_work_due;
            got.cadence_work_due = cadence_work_due;
            got.log_due = log_due;
            got.effective_threshold = effective_threshold;
            got.ticks_since_stimulus = ticks_since_stimulus;
            tracker.compare_result(got);
        end
    end

    task automatic send_request(logic is_stimulus, logic [7:0] stress);
        in_valid <= 1'b1;
        kind <= is_stimulus;
        stress_level <= stress;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.apply_request(is_stimulus, stress);
    endtask

    task automatic set_register(cfg_index_t idx, logic [CFG_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.write_register(idx, value);
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_stress();
        int r;
        int v;
        r = int'($urandom_range(0, 99));
        if (r < 45)
            v = int'(last_stress) + int'($urandom_range(0, 40)) - 20;
        else if (r < 65)
            v = int'(tracker.held_stress)
                + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(15, 16));
        else if (r < 80)
            v = int'($urandom_range(0, 255));
        else if (r < 90)
            v = 255;
        else
            v = 0;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        last_stress = 8'(v);
        return 8'(v);
    endfunction

    task automatic run_traffic(int count);
        int sent;
        int burst;
        int gap;
        int wake_pct;
        bit drain;
        sent = 0;
        while (sent < count)
        begin
            burst = int'($urandom_range(1, 24));
            case ($urandom_range(0, 2))
                0: wake_pct = 3;
                1: wake_pct = 10;
                default: wake_pct = 30;
            endcase
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_request(int'($urandom_range(0, 99)) < wake_pct, pick_stress());
                sent++;
            end
            gap = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 8));
            drain = ($urandom_range(0, 11) == 0);
            if (sent >= count || drain || gap != 0)
            begin
                in_valid <= 1'b0;
                if (drain)
                    wait_drained();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        logic [CFG_WIDTH-1:0] b;
        logic [CFG_WIDTH-1:0] lc;
        logic [CFG_WIDTH-1:0] wc;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // seed high, re-count while idle, wake, walk the stress band edges
        send_request(1'b0, 8'd255);
        send_request(1'b0, 8'd255);
        send_request(1'b0, 8'd240);
        send_request(1'b1, 8'd0);
        send_request(1'b1, 8'd170);
        send_request(1'b0, 8'd0);
        send_request(1'b0, 8'd15);
        send_request(1'b0, 8'd16);
        send_request(1'b0, 8'd31);
        send_request(1'b0, 8'd32);
        send_request(1'b0, 8'd128);
        send_request(1'b0, 8'd127);
        send_request(1'b1, 8'd85);
        send_request(1'b0, 8'd254);
        send_request(1'b0, 8'd1);
        send_request(1'b1, 8'd255);
        send_request(1'b0, 8'd170);
        send_request(1'b0, 8'd85);
        in_valid <= 1'b0;
        last_stress = 8'd85;
        wait_drained();

        run_traffic(200);
        wait_drained();

        for (int p = 0; p < 9; p++)
        begin
            if (p < 6)
            begin
                b = fixed_base[p];
                lc = fixed_log[p];
                wc = fixed_work[p];
            end
            else if (p < 8)
            begin
                b = CFG_WIDTH'($urandom_range(1, 48));
                lc = CFG_WIDTH'($urandom_range(1, 9));
                wc = CFG_WIDTH'($urandom_range(1, 9));
            end
            else
            begin
                b = BASE_THRESHOLD_RST;
                lc = LOG_CADENCE_RST;
                wc = WORK_CADENCE_RST;
            end
            set_register(CFG_BASE_THRESHOLD, b);
            set_register(CFG_LOG_CADENCE, lc);
            set_register(CFG_WORK_CADENCE, wc);
            settings_used++;
            run_traffic(200);
            wait_drained();
        end

        repeat (64) @(posedge clk);
        $display("%0d requests over %0d register settings, %0d results checked",
                 tracker.requests, settings_used, tracker.results_seen);
        $display("idle entries %0d, wakeups %0d, work flags %0d, log flags %0d, moves %0d",
                 tracker.entries, tracker.wakeups, tracker.work_flags,
                 tracker.log_flags, tracker.threshold_moves);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("** stress_modulated_idle_detector: PASSED **");
        else
            $display("** stress_modulated_idle_detector: FAILED **");
        $finish;
    end

endmodule
